/* hdl/csc_ccm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ccm_pkg
// Shared types and constants for the crank cadence meter.
// ----------------------------------------------------------------------------
package csc_ccm_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 4;
    localparam int FLAGS_W     = 2;
    localparam int GATHER_W    = 24;
    localparam int CNT16_W     = 16;
    localparam int RPM_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA_REVS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CADENCE    = 2'd1;

    localparam logic [CNT16_W-1:0] MAX_DELTA_REVS_RST = 16'd20;
    localparam logic [RPM_W-1:0]   MAX_CADENCE_RST    = 10'd250;

    localparam int FLAG_WHEEL = 0;
    localparam int FLAG_CRANK = 1;

    localparam logic [POS_W-1:0] POS_FLAGS       = 4'd0;
    localparam logic [POS_W-1:0] POS_LAST        = 4'd15;
    localparam logic [POS_W-1:0] CRANK_START     = 4'd1;
    localparam logic [POS_W-1:0] CRANK_START_WHL = 4'd7;
    localparam logic [POS_W-1:0] CRANK_LAST_OFS  = 4'd3;

    // sample queue
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // arithmetic widths
    localparam int NUM_W   = 32;                  // revs * 61440
    localparam int LIM_W   = RPM_W + CNT16_W;     // max_cadence * dt
    localparam int REM_W   = CNT16_W + 1 + RPM_W; // below 2*dt*1024
    localparam int STEP_W  = $clog2(RPM_W);

    typedef struct packed {
        logic [CNT16_W-1:0] revs;
        logic [CNT16_W-1:0] etime;
        logic               first;
    } sample_t;

    typedef struct packed {
        logic [CNT16_W-1:0] max_delta_revs;
        logic [RPM_W-1:0]   max_cadence;
    } cfg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_TEST,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

/* hdl/csc_ccm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ccm_front
// Frame parser: walks the flags byte, skips wheel data, gathers the crank
// revolutions and event time, and pushes one sample per complete crank field.
// ----------------------------------------------------------------------------
module csc_ccm_front
    import csc_ccm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              frame_end,
    input  logic              resync,
    input  logic              q_full,
    output logic              q_push,
    output sample_t           q_wdata
);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [FLAGS_W-1:0]  flags_reg, flags_next;
    logic [GATHER_W-1:0] gather_reg, gather_next;
    logic                have_prev_reg, have_prev_next;

    logic                accept;
    logic [POS_W-1:0]    start;
    logic [POS_W-1:0]    ofs;
    logic                hp;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pos_next       = pos_reg;
        flags_next     = flags_reg;
        gather_next    = gather_reg;
        have_prev_next = have_prev_reg;
        q_push         = 1'b0;
        hp             = have_prev_reg && !resync;
        start          = flags_reg[FLAG_WHEEL] ? CRANK_START_WHL : CRANK_START;
        ofs            = pos_reg - start;
        q_wdata.revs   = gather_reg[15:0];
        q_wdata.etime  = {data_byte, gather_reg[23:16]};
        q_wdata.first  = !hp;

        if (accept)
        begin
            have_prev_next = hp;
            if (pos_reg == POS_FLAGS)
            begin
                flags_next = data_byte[FLAGS_W-1:0];
            end
            else if (flags_reg[FLAG_CRANK] && pos_reg >= start
                     && pos_reg <= start + CRANK_LAST_OFS)
            begin
                case (ofs[1:0])
                    2'd0: gather_next[7:0]   = data_byte;
                    2'd1: gather_next[15:8]  = data_byte;
                    2'd2: gather_next[23:16] = data_byte;
                    default:
                    begin
                        // last crank byte completes the sample
                        q_push         = 1'b1;
                        have_prev_next = 1'b1;
                    end
                endcase
            end

            if (frame_end)
                pos_next = POS_FLAGS;
            else if (pos_reg != POS_LAST)
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_FLAGS;
            flags_reg     <= '0;
            gather_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            flags_reg     <= flags_next;
            gather_reg    <= gather_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

/* hdl/csc_ccm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ccm_queue
// Short sample queue between the frame parser and the cadence engine.
// ----------------------------------------------------------------------------
module csc_ccm_queue
    import csc_ccm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sample_t wdata,
    input  logic    pop,
    output sample_t rdata,
    output logic    empty,
    output logic    full
);

    sample_t            mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == QCNT_W'(0));
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/csc_ccm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ccm_back
// Cadence engine: forms wrapping deltas against the stored sample, applies
// the bounds, and divides with rounding one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csc_ccm_back
    import csc_ccm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_empty,
    input  sample_t          q_rdata,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [RPM_W-1:0] cadence_rpm
);

    back_state_t        state_reg, state_next;
    logic [CNT16_W-1:0] prev_revs_reg, prev_revs_next;
    logic [CNT16_W-1:0] prev_time_reg, prev_time_next;
    logic [CNT16_W-1:0] dr_reg, dr_next;
    logic [CNT16_W-1:0] dt_reg, dt_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [LIM_W-1:0]   lim_reg, lim_next;
    logic               ok_reg, ok_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   dsh_reg, dsh_next;
    logic [RPM_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic [RPM_W-1:0]   rpm_reg, rpm_next;

    logic [NUM_W:0]     dividend;
    logic               out_free;

    assign out_valid   = out_valid_reg;
    assign cadence_rpm = rpm_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    // rounding: (2*num + dt) / (2*dt)
    assign dividend    = {num_reg, 1'b0} + (NUM_W + 1)'(dt_reg);

    always_comb
    begin
        state_next     = state_reg;
        prev_revs_next = prev_revs_reg;
        prev_time_next = prev_time_reg;
        dr_next        = dr_reg;
        dt_next        = dt_reg;
        num_next       = num_reg;
        lim_next       = lim_reg;
        ok_next        = ok_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        rpm_next       = rpm_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop          = 1'b1;
                    dr_next        = q_rdata.revs - prev_revs_reg;
                    dt_next        = q_rdata.etime - prev_time_reg;
                    prev_revs_next = q_rdata.revs;
                    prev_time_next = q_rdata.etime;
                    if (!q_rdata.first)
                        state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                // 61440 * dr as (dr << 16) - (dr << 12)
                num_next   = {dr_reg, 16'd0} - {4'd0, dr_reg, 12'd0};
                lim_next   = cfg.max_cadence * dt_reg;
                ok_next    = (dt_reg != '0) && (dr_reg != '0)
                             && (dr_reg < cfg.max_delta_revs);
                state_next = B_TEST;
            end
            B_TEST:
            begin
                if (ok_reg && num_reg < NUM_W'(lim_reg))
                begin
                    rem_next   = dividend[REM_W-1:0];
                    dsh_next   = REM_W'({dt_reg, 1'b0}) << (RPM_W - 1);
                    quo_next   = '0;
                    step_next  = STEP_W'(RPM_W - 1);
                    state_next = B_DIV;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[RPM_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[RPM_W-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    rpm_next       = quo_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            prev_revs_reg <= '0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_revs_reg <= prev_revs_next;
            prev_time_reg <= prev_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        dt_reg   <= dt_next;
        num_reg  <= num_next;
        lim_reg  <= lim_next;
        ok_reg   <= ok_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        rpm_reg  <= rpm_next;
    end

endmodule

/* hdl/csc_crank_cadence_meter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_crank_cadence_meter_core
// Crank cadence meter for cycling speed and cadence measurement frames.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle while the input is not stalled. Each
// complete crank field becomes a sample in a two-entry queue. A sample that
// reaches the cadence divider passes through delta, bounds check, rounding
// test, ten restoring division steps at one quotient bit per cycle, and the
// output load. A sample that fails a bound ends at the rounding test, and one
// that is only stored ends at the delta. The output load waits while an earlier
// result is still held. The byte input stalls only while two samples wait
// in the queue. A crank field takes at least five bytes, so the input
// stalls when crank fields arrive faster than the engine drains them, or
// while a held result blocks the engine. A result sits in an output
// register and is held there while out_stall is high.
module csc_crank_cadence_meter_core
    import csc_ccm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  frame_end,
    input  logic                  resync,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [RPM_W-1:0]      cadence_rpm
);

    cfg_t    cfg_reg, cfg_next;
    logic    q_push;
    logic    q_pop;
    logic    q_empty;
    logic    q_full;
    sample_t q_wdata;
    sample_t q_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_DELTA_REVS: cfg_next.max_delta_revs = cfg_data;
                REG_MAX_CADENCE:    cfg_next.max_cadence    = cfg_data[RPM_W-1:0];
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_delta_revs <= MAX_DELTA_REVS_RST;
            cfg_reg.max_cadence    <= MAX_CADENCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    csc_ccm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .resync    (resync),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    csc_ccm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    csc_ccm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cadence_rpm (cadence_rpm)
    );

endmodule

/* hdl/csc_ccm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ccm_checker
// Port-level checks for the crank cadence meter, bound to the top level.
// ----------------------------------------------------------------------------
module csc_ccm_checker
    import csc_ccm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [RPM_W-1:0] cadence_rpm
);

    // a stalled result word stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cadence_rpm))
        else $error("result word changed while stalled");

    // rounded cadence is never zero
    a_rpm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cadence_rpm != '0)
        else $error("zero cadence emitted");

    // the queue fills only on the edge of an accepted byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without an accepted word");

endmodule

bind csc_crank_cadence_meter_core csc_ccm_checker u_csc_ccm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cadence_rpm (cadence_rpm)
);

/* verif/tb_csc_crank_cadence_meter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csc_crank_cadence_meter_core
// Self-checking bench for the crank cadence meter core.
// ----------------------------------------------------------------------------
// Measurement frames are fed one byte per word with random gaps on the input
// side and random stall on the cadence side. A bit-exact predictor in the
// scoreboard tracks frame parsing, the stored crank sample and both limit
// registers, and queues the cadence each accepted byte should produce. Each
// cadence word leaving the core is checked against the oldest queued value.
// The run walks through default, extreme and random register settings, with
// well-formed crank frames mixed with short frames, non-crank frames, long
// frames, resyncs and random byte noise.
// ----------------------------------------------------------------------------
module tb_csc_crank_cadence_meter_core;
    import csc_ccm_pkg::*;

    localparam longint unsigned RPM_SCALE = 61440; // 60 s * 1024 ticks per s
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES   = 64;
    localparam int STUCK_LIMIT    = 2000;
    localparam int BYTE_QUOTA     = 1250;
    localparam int MAX_RAND_PHASE = 40;

    typedef logic [BYTE_W-1:0] frame_t[$];

    class cadence_scoreboard;
        logic [CNT16_W-1:0] lim_revs;
        logic [RPM_W-1:0]   lim_rpm;
        logic [POS_W-1:0]   pos;
        logic [FLAGS_W-1:0] flags;
        logic [GATHER_W-1:0] gather;
        logic [CNT16_W-1:0] prev_revs;
        logic [CNT16_W-1:0] prev_time;
        bit                 have_prev;
        logic [RPM_W-1:0]   rpm_q[$];
        int                 errors;
        int                 arrived;

        function new();
            lim_revs  = MAX_DELTA_REVS_RST;
            lim_rpm   = MAX_CADENCE_RST;
            pos       = POS_FLAGS;
            flags     = '0;
            gather    = '0;
            prev_revs = '0;
            prev_time = '0;
            have_prev = 1'b0;
            errors    = 0;
            arrived   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MAX_DELTA_REVS: lim_revs = data;
                REG_MAX_CADENCE:    lim_rpm  = data[RPM_W-1:0];
                default: ;
            endcase
        endfunction

        function void crank_sample(logic [CNT16_W-1:0] revs, logic [CNT16_W-1:0] tm);
            logic [CNT16_W-1:0] dr;
            logic [CNT16_W-1:0] dt;
            longint unsigned num;
            longint unsigned rounded;
            if (have_prev)
            begin
                dr = revs - prev_revs;
                dt = tm - prev_time;
                if (dt != 0 && dr != 0 && dr < lim_revs)
                begin
                    num = longint'(dr) * RPM_SCALE;
                    if (num < longint'(lim_rpm) * longint'(dt))
                    begin
                        rounded = (2 * num + dt) / (2 * longint'(dt));
                        rpm_q.push_back(rounded[RPM_W-1:0]);
                    end
                end
            end
            have_prev = 1'b1;
            prev_revs = revs;
            prev_time = tm;
        endfunction

        // Advance the frame parser by one accepted byte.
        function void take_byte(logic [BYTE_W-1:0] b, logic fe, logic rs);
            int start;
            int k;
            if (rs)
                have_prev = 1'b0;
            if (pos == POS_FLAGS)
                flags = b[FLAGS_W-1:0];
            else if (flags[FLAG_CRANK])
            begin
                start = flags[FLAG_WHEEL] ? int'(CRANK_START_WHL) : int'(CRANK_START);
                if (pos >= start && pos <= start + CRANK_LAST_OFS)
                begin
                    k = pos - start;
                    if (k < CRANK_LAST_OFS)
                        gather[8*k +: 8] = b;
                    else
                        crank_sample(gather[15:0], {b, gather[23:16]});
                end
            end
            if (fe)
                pos = POS_FLAGS;
            else if (pos != POS_LAST)
                pos = pos + 1'b1;
        endfunction

        function void check_rpm(logic [RPM_W-1:0] got);
            logic [RPM_W-1:0] exp_rpm;
            arrived++;
            if (rpm_q.size() == 0)
            begin
                $error("cadence_rpm: unexpected word, expected none, actual %0d", got);
                errors++;
            end
            else
            begin
                exp_rpm = rpm_q.pop_front();
                if (got !== exp_rpm)
                begin
                    $error("cadence_rpm: expected %0d, actual %0d", exp_rpm, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return rpm_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte;
    logic                  frame_end;
    logic                  resync;
    logic                  out_valid;
    logic                  out_stall;
    logic [RPM_W-1:0]      cadence_rpm;

    cadence_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    int bytes_sent;
    int stuck;

    csc_crank_cadence_meter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .frame_end   (frame_end),
        .resync      (resync),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cadence_rpm (cadence_rpm)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Check cadence words, drive receiver stall, watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_rpm(cadence_rpm);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
        if (stuck >= STUCK_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fe, input logic rs);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        frame_end <= fe;
        resync    <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_byte(b, fe, rs);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_t f, input int rs_at);
        for (int i = 0; i < f.size(); i++)
            push_byte(f[i], i == f.size() - 1, i == rs_at);
    endtask

    function automatic frame_t crank_frame(input logic [BYTE_W-1:0] flags,
                                           input logic [CNT16_W-1:0] revs,
                                           input logic [CNT16_W-1:0] tm,
                                           input int extra);
        frame_t f;
        f.push_back(flags);
        if (flags[FLAG_WHEEL])
            repeat (CRANK_START_WHL - CRANK_START) f.push_back(8'($urandom));
        f.push_back(revs[7:0]);
        f.push_back(revs[15:8]);
        f.push_back(tm[7:0]);
        f.push_back(tm[15:8]);
        repeat (extra) f.push_back(8'($urandom));
        return f;
    endfunction

    task automatic random_frame();
        int sel;
        int rs_at;
        int n;
        logic [BYTE_W-1:0]  flags;
        logic [CNT16_W-1:0] dr;
        logic [CNT16_W-1:0] dt;
        logic [CNT16_W-1:0] revs;
        logic [CNT16_W-1:0] tm;
        longint unsigned num;
        longint unsigned den;
        frame_t f;
        sel   = $urandom_range(0, 99);
        flags = 8'($urandom);
        rs_at = -1;
        if (sel < 80)
        begin
            flags[FLAG_CRANK] = 1'b1;
            case ($urandom_range(0, 9))
                0:       dr = '0;
                1:       dr = sb.lim_revs - 1'b1;
                2:       dr = sb.lim_revs;
                3:       dr = 16'($urandom);
                default: dr = 16'($urandom_range(1, 12));
            endcase
            num = longint'(dr) * RPM_SCALE;
            den = (sb.lim_rpm == 0) ? 64'd1 : 64'(sb.lim_rpm);
            case ($urandom_range(0, 9))
                0:       dt = '0;
                1:       dt = 16'($urandom);
                2:       dt = 16'(num / den);          // right at the cadence limit
                3:       dt = 16'(num / den + 1);
                default: dt = 16'(num / $urandom_range(20, 1100));
            endcase
            if (sb.have_prev)
            begin
                revs = sb.prev_revs + dr;
                tm   = sb.prev_time + dt;
            end
            else
            begin
                revs = 16'($urandom);
                tm   = 16'($urandom);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            f = crank_frame(flags, revs, tm, n);
            // cut the frame before its last crank byte
            if (sel >= 68)
            begin
                n = $urandom_range(1, f.size() - n - 1);
                while (f.size() > n)
                    void'(f.pop_back());
            end
            if ($urandom_range(0, 24) == 0)
                rs_at = 0;
            else if ($urandom_range(0, 49) == 0)
                rs_at = $urandom_range(0, f.size() - 1);
            send_frame(f, rs_at);
        end
        else if (sel < 90)
        begin
            flags[FLAG_CRANK] = 1'b0;
            f.push_back(flags);
            repeat ($urandom_range(0, 11)) f.push_back(8'($urandom));
            if ($urandom_range(0, 9) == 0)
                rs_at = $urandom_range(0, f.size() - 1);
            send_frame(f, rs_at);
        end
        else
        begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom), i == n - 1 || $urandom_range(0, 4) == 0,
                          $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic run_phase(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
            random_frame();
    endtask

    // Hold input until every cadence is out and the engine has drained.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_limits(input logic [CNT16_W-1:0] revs_lim,
                                  input logic [RPM_W-1:0] rpm_lim,
                                  input bit spare);
        logic [CFG_IDX_W-1:0]  idx[$];
        logic [CFG_DATA_W-1:0] val[$];
        if (spare)
        begin
            idx.push_back(REG_SPARE);
            val.push_back(16'($urandom));
        end
        idx.push_back(REG_MAX_DELTA_REVS);
        val.push_back(revs_lim);
        idx.push_back(REG_MAX_CADENCE);
        val.push_back({6'($urandom), rpm_lim});
        cfg_we <= 1'b1;
        for (int i = 0; i < idx.size(); i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_frames();
        // first sample after resync is only stored
        send_frame({8'h02, 8'h00, 8'h00, 8'h00, 8'h00}, 0);
        // one rev in 8192 ticks is 7.5 rpm, rounds up to 8
        send_frame({8'h02, 8'h01, 8'h00, 8'h00, 8'h20}, -1);
        // wheel data skipped, one rev in one second, trailing byte ignored
        send_frame({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h02, 8'h00, 8'h00, 8'h24, 8'hFF}, -1);
        // short crank frame, then a flags-only frame
        send_frame({8'h02, 8'hAA}, -1);
        send_frame({8'h00}, -1);
    endtask

    initial
    begin
        int phases;
        sb           = new();
        in_idle_pct  = 19;
        out_idle_pct = 19;
        bytes_sent   = 0;
        stuck        = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_MAX_DELTA_REVS;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        data_byte    <= '0;
        frame_end    <= 1'b0;
        resync       <= 1'b0;
        out_stall    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_frames();
        run_phase(300);

        // widest limits, no idling on either side
        settle();
        program_limits(16'hFFFF, 10'd1023, 1'b0);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_phase(300);
        in_idle_pct  = 19;
        out_idle_pct = 19;

        // limits that block every cadence
        settle();
        program_limits(16'd1, 10'd1023, 1'b1);
        run_phase(60);
        settle();
        program_limits(16'd0, 10'd512, 1'b0);
        run_phase(60);
        settle();
        program_limits(16'd100, 10'd0, 1'b0);
        run_phase(60);

        phases = 0;
        while (bytes_sent < BYTE_QUOTA && phases < MAX_RAND_PHASE)
        begin
            settle();
            program_limits(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(2, 40)),
                           10'($urandom_range(1, 1023)), 1'b0);
            run_phase(150);
            phases++;
        end

        settle();
        if (sb.pending() != 0)
        begin
            $error("cadence_rpm: %0d expected words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/csc_ccm_pkg.sv
hdl/csc_ccm_front.sv
hdl/csc_ccm_queue.sv
hdl/csc_ccm_back.sv
hdl/csc_crank_cadence_meter_core.sv
hdl/csc_ccm_checker.sv
verif/tb_csc_crank_cadence_meter_core.sv
